// File: rtl/latlon_grid_cell_area_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the lat/lon grid cell area block
// Shared concurrent checks, clocked on aclk and muted during reset.
// ----------------------------------------------------------------------------
`ifndef LATLON_GRID_CELL_AREA_TOP_DEFINES_SVH
`define LATLON_GRID_CELL_AREA_TOP_DEFINES_SVH

// same-cycle implication
`define LLCA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LLCA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/llca_pkg.sv
// ----------------------------------------------------------------------------
// llca_pkg
// Shared constants, configuration type and CORDIC angle table.
// ----------------------------------------------------------------------------
package llca_pkg;

    localparam int ROW_INDEX_BITS = 16;
    localparam int ROW_TDATA_W    = ((ROW_INDEX_BITS + 7) / 8) * 8;
    localparam int AREA_W         = 37;
    localparam int AREA_TDATA_W   = ((AREA_W + 7) / 8) * 8;
    localparam int CFG_IDX_W      = 8;
    localparam int CFG_DATA_W     = 25;

    localparam logic [CFG_IDX_W-1:0] REG_LAT_ORIGIN    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LAT_STEP      = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LON_STEP      = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPHERE_RADIUS = 8'd3;

    localparam logic [12:0] RADIUS_RESET = 13'd6371;

    // angles in Q17 degrees, modulo domain [0, 360)
    localparam int ANG_W = 26;
    localparam int RED_W = 28;
    localparam logic [ANG_W-1:0] DEG360 = 26'd47185920;
    localparam logic [ANG_W-1:0] DEG270 = 26'd35389440;
    localparam logic [ANG_W-1:0] DEG180 = 26'd23592960;
    localparam logic [ANG_W-1:0] DEG90  = 26'd11796480;
    localparam int ABS_W = 24;

    // floor(pi * 2^60 / 180)
    localparam logic [54:0] RPD = 55'd20122276272436452;

    localparam int CORDIC_ITERS = 32;
    localparam int XY_W = 34;
    localparam int Z_W  = 35;
    localparam logic [XY_W-1:0] CORDIC_GAIN = 34'd652032874;

    localparam int DIFF_W = 34;
    localparam int B_W    = 54;
    localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

    typedef struct packed {
        logic [23:0] lat_origin;
        logic [23:0] lat_step;
        logic [24:0] lon_step;
        logic [12:0] sphere_radius;
    } llca_cfg_t;

    // atan(2^-i) in Q32 radians
    function automatic logic [31:0] atan_tab(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'd3373259426;
            1:  v = 32'd1991351317;
            2:  v = 32'd1052175346;
            3:  v = 32'd534100634;
            4:  v = 32'd268086747;
            5:  v = 32'd134174062;
            6:  v = 32'd67103403;
            7:  v = 32'd33553749;
            8:  v = 32'd16777130;
            9:  v = 32'd8388597;
            10: v = 32'd4194302;
            default: begin
                if (i <= 20) begin
                    v = (32'd1 << (32 - i)) - 32'd1;
                end else begin
                    v = 32'd1 << (32 - i);
                end
            end
        endcase
        return v;
    endfunction

endpackage

// File: rtl/latlon_grid_cell_area_top.sv
// ----------------------------------------------------------------------------
// latlon_grid_cell_area_top
// Surface area of one equal-angle lat/lon grid cell on a sphere.
// ----------------------------------------------------------------------------
// Usage:
//   Send requests on the s_ stream: s_tdata carries the row index, s_tuser
//   the mode (0 cell centred on the row latitude, 1 cell anchored at its
//   lower edge). One area result per request leaves on the m_ stream, in
//   request order, as Q8 square kilometres saturated at 2^37-1.
//   Registers are written on the cfg_ channel (index 0 lat_origin,
//   1 lat_step, 2 lon_step, 3 sphere_radius); other indexes are dropped.
//   Write them only while no request is in flight.
// Timing:
//   One request per cycle sustained while no output stall holds the pipeline.
//   The pipeline is one Horner stage per row bit for the modulo-360 latitude,
//   four stages of angle wrap, fold and radian multiply, one stage per
//   CORDIC iteration (32), three stages of area product, and the output
//   register.
// Reset:
//   aresetn low synchronously empties the pipeline and restores the
//   registers (radius 6371 km, others zero).
// Stall:
//   While m_tready is low one more result parks in a skid register; then
//   s_tready drops and the whole pipeline holds until the output drains.
// ----------------------------------------------------------------------------
`include "latlon_grid_cell_area_top_defines.svh"

module latlon_grid_cell_area_top import llca_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    // request stream
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [ROW_TDATA_W-1:0]  s_tdata,   // [ROW_INDEX_BITS-1:0] row_index, rest zero
    input  logic [0:0]              s_tuser,   // [0] op
    // result stream
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [AREA_TDATA_W-1:0] m_tdata,   // [36:0] cell_area, rest zero
    // register writes
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    // register file
    llca_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lat_origin    <= '0;
            cfg_reg.lat_step      <= '0;
            cfg_reg.lon_step      <= '0;
            cfg_reg.sphere_radius <= RADIUS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_LAT_ORIGIN:    cfg_reg.lat_origin    <= cfg_data[23:0];
                REG_LAT_STEP:      cfg_reg.lat_step      <= cfg_data[23:0];
                REG_LON_STEP:      cfg_reg.lon_step      <= cfg_data;
                REG_SPHERE_RADIUS: cfg_reg.sphere_radius <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // advance the whole pipeline unless the skid register is occupied
    logic pipe_en;
    logic skid_valid_reg;
    assign pipe_en  = !skid_valid_reg;
    assign s_tready = pipe_en;

    logic                   ang_valid;
    logic signed [Z_W-1:0]  z_top;
    logic signed [Z_W-1:0]  z_bot;
    logic                   cor_valid;
    logic signed [XY_W-1:0] y_top;
    logic signed [XY_W-1:0] y_bot;
    logic                   end_valid;
    logic [AREA_W-1:0]      end_area;

    llca_angle u_angle (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_op     (s_tuser[0]),
        .in_row    (s_tdata[ROW_INDEX_BITS-1:0]),
        .out_valid (ang_valid),
        .z_top     (z_top),
        .z_bot     (z_bot)
    );

    llca_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (ang_valid),
        .z_top     (z_top),
        .z_bot     (z_bot),
        .out_valid (cor_valid),
        .y_top     (y_top),
        .y_bot     (y_bot)
    );

    llca_area u_area (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .cfg       (cfg_reg),
        .in_valid  (cor_valid),
        .y_top     (y_top),
        .y_bot     (y_bot),
        .out_valid (end_valid),
        .area      (end_area)
    );

    // output register plus one skid entry
    logic              out_valid_reg;
    logic [AREA_W-1:0] out_area_reg;
    logic [AREA_W-1:0] skid_area_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= end_valid;
            end
        end else if (end_valid && pipe_en) begin
            // output stalled: park the arriving result
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            out_area_reg <= skid_valid_reg ? skid_area_reg : end_area;
        end else if (end_valid && pipe_en) begin
            skid_area_reg <= end_area;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(AREA_TDATA_W - AREA_W){1'b0}}, out_area_reg};

    `LLCA_ASSERT_NOW(a_skid_has_out, skid_valid_reg, out_valid_reg, "skid filled without output")
    `LLCA_ASSERT_NOW(a_skid_on_stall, $rose(skid_valid_reg),
        $past(out_valid_reg && !m_tready), "skid filled while output was free")
    `LLCA_ASSERT_NEXT(a_skid_holds, skid_valid_reg && !m_tready, skid_valid_reg,
        "skid entry dropped during stall")

endmodule

// File: rtl/llca_angle.sv
// ----------------------------------------------------------------------------
// llca_angle
// Edge latitudes modulo 360 degrees, folded and converted to Q32 radians.
// ----------------------------------------------------------------------------
module llca_angle import llca_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  llca_cfg_t                     cfg,
    input  logic                          in_valid,
    input  logic                          in_op,
    input  logic [ROW_INDEX_BITS-1:0]     in_row,
    output logic                          out_valid,
    output logic signed [Z_W-1:0]         z_top,
    output logic signed [Z_W-1:0]         z_bot
);

    localparam int N = ROW_INDEX_BITS;
    localparam logic [RED_W-1:0] M28  = {2'b00, DEG360};
    localparam logic [RED_W-1:0] M2X  = {1'b0, DEG360, 1'b0};

    // twice the step, reduced into [0, 360)
    logic [ANG_W-1:0] step2_raw;
    logic [ANG_W-1:0] step2_mod;
    assign step2_raw = {cfg.lat_step[23], cfg.lat_step, 1'b0};
    assign step2_mod = step2_raw[ANG_W-1] ? step2_raw + DEG360 : step2_raw;

    logic             hv_reg   [N];
    logic             hop_reg  [N];
    logic [N-1:0]     hrow_reg [N];
    logic [ANG_W-1:0] hr_reg   [N];

    // Horner over the row bits, MSB first: r = (2r + bit * 2step) mod 360
    for (genvar k = 0; k < N; k++) begin : g_horner
        logic             v_in;
        logic             op_in;
        logic [N-1:0]     row_in;
        logic [ANG_W-1:0] r_in;
        logic [RED_W-1:0] acc;
        logic [RED_W-1:0] red;
        if (k == 0) begin : g_first
            assign v_in   = in_valid;
            assign op_in  = in_op;
            assign row_in = in_row;
            assign r_in   = '0;
        end else begin : g_next
            assign v_in   = hv_reg[k-1];
            assign op_in  = hop_reg[k-1];
            assign row_in = hrow_reg[k-1];
            assign r_in   = hr_reg[k-1];
        end
        assign acc = {1'b0, r_in, 1'b0} + (row_in[N-1] ? {2'b00, step2_mod} : '0);
        always_comb begin
            if (acc >= M2X) begin
                red = acc - M2X;
            end else if (acc >= M28) begin
                red = acc - M28;
            end else begin
                red = acc;
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                hv_reg[k] <= 1'b0;
            end else if (en) begin
                hv_reg[k] <= v_in;
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                hop_reg[k]  <= op_in;
                hrow_reg[k] <= {row_in[N-2:0], 1'b0};
                hr_reg[k]   <= red[ANG_W-1:0];
            end
        end
    end

    // add origin and the edge offsets, one wrap back into [0, 360)
    logic signed [RED_W-1:0] org2;
    logic signed [RED_W-1:0] stp1;
    logic signed [RED_W-1:0] stp2;
    logic signed [RED_W-1:0] c_edge [2];
    logic signed [RED_W-1:0] sum    [2];
    assign org2 = {{3{cfg.lat_origin[23]}}, cfg.lat_origin, 1'b0};
    assign stp1 = {{4{cfg.lat_step[23]}}, cfg.lat_step};
    assign stp2 = {{3{cfg.lat_step[23]}}, cfg.lat_step, 1'b0};
    assign c_edge[0] = hop_reg[N-1] ? stp2 : stp1;
    assign c_edge[1] = hop_reg[N-1] ? '0 : -stp1;

    logic             ev_reg;
    logic [ANG_W-1:0] e_reg [2];
    logic             fv_reg;
    logic             fneg_reg [2];
    logic [ABS_W-1:0] fabs_reg [2];
    logic             mv_reg;
    logic             mneg_reg [2];
    logic [ABS_W-1:0] mabs_reg [2];
    logic [55:0]      mlo_reg  [2];
    logic             zv_reg;
    logic signed [Z_W-1:0] z_reg [2];

    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic signed [RED_W-1:0] wrap;
        logic signed [ANG_W:0]   t;
        logic signed [ANG_W:0]   t_abs;
        logic [46:0]             hi;
        logic [47:0]             mag_sum;
        logic [Z_W-1:0]          mag;
        assign sum[l] = $signed({2'b00, hr_reg[N-1]}) + org2 + c_edge[l];
        always_comb begin
            if (sum[l][RED_W-1]) begin
                wrap = sum[l] + $signed(M28);
            end else if (sum[l] >= $signed(M28)) begin
                wrap = sum[l] - $signed(M28);
            end else begin
                wrap = sum[l];
            end
        end
        // fold into [-90, 90] keeping the sine
        always_comb begin
            if (e_reg[l] <= DEG90) begin
                t = $signed({1'b0, e_reg[l]});
            end else if (e_reg[l] <= DEG270) begin
                t = $signed({1'b0, DEG180}) - $signed({1'b0, e_reg[l]});
            end else begin
                t = $signed({1'b0, e_reg[l]}) - $signed({1'b0, DEG360});
            end
        end
        assign t_abs   = t[ANG_W] ? -t : t;
        assign hi      = mabs_reg[l] * RPD[54:32];
        assign mag_sum = {1'b0, hi} + {24'd0, mlo_reg[l][55:32]};
        assign mag     = mag_sum[47:13];
        always_ff @(posedge aclk) begin
            if (en) begin
                e_reg[l]    <= wrap[ANG_W-1:0];
                fneg_reg[l] <= t[ANG_W];
                fabs_reg[l] <= t_abs[ABS_W-1:0];
                mneg_reg[l] <= fneg_reg[l];
                mabs_reg[l] <= fabs_reg[l];
                mlo_reg[l]  <= fabs_reg[l] * RPD[31:0];
                z_reg[l]    <= mneg_reg[l] ? -$signed(mag) : $signed(mag);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ev_reg <= 1'b0;
            fv_reg <= 1'b0;
            mv_reg <= 1'b0;
            zv_reg <= 1'b0;
        end else if (en) begin
            ev_reg <= hv_reg[N-1];
            fv_reg <= ev_reg;
            mv_reg <= fv_reg;
            zv_reg <= mv_reg;
        end
    end

    assign out_valid = zv_reg;
    assign z_top     = z_reg[0];
    assign z_bot     = z_reg[1];

endmodule

// File: rtl/llca_cordic.sv
// ----------------------------------------------------------------------------
// llca_cordic
// Dual-lane rotation CORDIC, one iteration per pipeline stage.
// ----------------------------------------------------------------------------
module llca_cordic import llca_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic signed [Z_W-1:0]  z_top,
    input  logic signed [Z_W-1:0]  z_bot,
    output logic                   out_valid,
    output logic signed [XY_W-1:0] y_top,
    output logic signed [XY_W-1:0] y_bot
);

    logic                   v_reg [CORDIC_ITERS];
    logic signed [XY_W-1:0] x_reg [CORDIC_ITERS][2];
    logic signed [XY_W-1:0] y_reg [CORDIC_ITERS][2];
    logic signed [Z_W-1:0]  z_reg [CORDIC_ITERS][2];

    for (genvar k = 0; k < CORDIC_ITERS; k++) begin : g_iter
        localparam logic signed [Z_W-1:0] ANG = $signed({3'b000, atan_tab(k)});
        logic v_in;
        if (k == 0) begin : g_first
            assign v_in = in_valid;
        end else begin : g_next
            assign v_in = v_reg[k-1];
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_in;
            end
        end
        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic signed [XY_W-1:0] x_in;
            logic signed [XY_W-1:0] y_in;
            logic signed [Z_W-1:0]  z_in;
            logic signed [XY_W-1:0] dx;
            logic signed [XY_W-1:0] dy;
            if (k == 0) begin : g_first
                assign x_in = $signed(CORDIC_GAIN);
                assign y_in = '0;
                assign z_in = (l == 0) ? z_top : z_bot;
            end else begin : g_next
                assign x_in = x_reg[k-1][l];
                assign y_in = y_reg[k-1][l];
                assign z_in = z_reg[k-1][l];
            end
            assign dx = y_in >>> k;
            assign dy = x_in >>> k;
            always_ff @(posedge aclk) begin
                if (en) begin
                    if (!z_in[Z_W-1]) begin
                        x_reg[k][l] <= x_in - dx;
                        y_reg[k][l] <= y_in + dy;
                        z_reg[k][l] <= z_in - ANG;
                    end else begin
                        x_reg[k][l] <= x_in + dx;
                        y_reg[k][l] <= y_in - dy;
                        z_reg[k][l] <= z_in + ANG;
                    end
                end
            end
        end
    end

    assign out_valid = v_reg[CORDIC_ITERS-1];
    assign y_top     = y_reg[CORDIC_ITERS-1][0];
    assign y_bot     = y_reg[CORDIC_ITERS-1][1];

endmodule

// File: rtl/llca_area.sv
// ----------------------------------------------------------------------------
// llca_area
// Area scale from radius and longitude step, times the sine difference.
// ----------------------------------------------------------------------------
module llca_area import llca_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  llca_cfg_t              cfg,
    input  logic                   in_valid,
    input  logic signed [XY_W-1:0] y_top,
    input  logic signed [XY_W-1:0] y_bot,
    output logic                   out_valid,
    output logic [AREA_W-1:0]      area
);

    // scale B = floor(r^2 * lon * RPD / 2^52), tracks the static registers
    logic [25:0]    sq_reg;
    logic [50:0]    a_reg;
    logic [57:0]    pp00_reg;
    logic [48:0]    pp01_reg;
    logic [56:0]    pp10_reg;
    logic [47:0]    pp11_reg;
    logic [B_W-1:0] b_reg;
    logic [105:0]   b_sum;

    assign b_sum = {48'd0, pp00_reg} + {25'd0, pp01_reg, 32'd0}
                 + {23'd0, pp10_reg, 26'd0} + {pp11_reg, 58'd0};

    always_ff @(posedge aclk) begin
        sq_reg   <= cfg.sphere_radius * cfg.sphere_radius;
        a_reg    <= sq_reg * cfg.lon_step;
        pp00_reg <= a_reg[25:0] * RPD[31:0];
        pp01_reg <= a_reg[25:0] * RPD[54:32];
        pp10_reg <= a_reg[50:26] * RPD[31:0];
        pp11_reg <= a_reg[50:26] * RPD[54:32];
        b_reg    <= b_sum[105:52];
    end

    logic signed [XY_W:0] dsub;
    logic signed [XY_W:0] dabs;
    assign dsub = $signed({y_top[XY_W-1], y_top}) - $signed({y_bot[XY_W-1], y_bot});
    assign dabs = dsub[XY_W] ? -dsub : dsub;

    logic              dv_reg;
    logic [DIFF_W-1:0] d_reg;
    logic              pv_reg;
    logic [60:0]       pl_reg;
    logic [60:0]       ph_reg;
    logic              sv_reg;
    logic [AREA_W-1:0] area_reg;
    logic [88:0]       prod;
    logic [42:0]       scaled;

    assign prod   = {28'd0, pl_reg} + {1'b0, ph_reg, 27'd0};
    assign scaled = prod[88:46];

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg    <= dabs[DIFF_W-1:0];
            pl_reg   <= d_reg * b_reg[26:0];
            ph_reg   <= d_reg * b_reg[53:27];
            area_reg <= (scaled > {6'd0, AREA_MAX}) ? AREA_MAX : scaled[AREA_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg <= 1'b0;
            pv_reg <= 1'b0;
            sv_reg <= 1'b0;
        end else if (en) begin
            dv_reg <= in_valid;
            pv_reg <= dv_reg;
            sv_reg <= pv_reg;
        end
    end

    assign out_valid = sv_reg;
    assign area      = area_reg;

endmodule

// File: verif/tb_latlon_grid_cell_area_top.sv
// ----------------------------------------------------------------------------
// tb_latlon_grid_cell_area_top
// Self-checking bench for the lat/lon grid cell area pipeline. An in-bench
// integer model (modulo-360 fold, CORDIC sine, truncating area products)
// predicts every area. Requests come in bursts and results are drained
// against a throttled, sometimes long-held m_tready.
// ----------------------------------------------------------------------------
module tb_latlon_grid_cell_area_top;
    import llca_pkg::*;

    localparam longint DEG360_Q17 = 64'd360 << 17;
    localparam longint DEG270_Q17 = 64'd270 << 17;
    localparam longint DEG180_Q17 = 64'd180 << 17;
    localparam longint DEG90_Q17  = 64'd90 << 17;
    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam int DRAIN_CYCLES = ROW_INDEX_BITS + 60;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [ROW_TDATA_W-1:0]  s_tdata;
    logic [0:0]              s_tuser;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [AREA_TDATA_W-1:0] m_tdata;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    latlon_grid_cell_area_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // shadow copy of the block's registers
    logic signed [23:0] grid_origin;
    logic signed [23:0] grid_step;
    logic [24:0]        grid_lon_step;
    logic [12:0]        grid_radius;

    longint    atan_q32 [CORDIC_ITERS];
    logic [36:0] area_expect [$];

    int errors;
    int rows_sent;
    int areas_checked;
    int saturated_seen;
    int rdy_mode;     // 0 always ready, 1 random throttle
    int hold_cycles;  // long receiver hold-off, counted down below

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic logic [63:0] mul_shr(input logic [63:0] a, input logic [63:0] b,
                                            input int sh);
        logic [127:0] p;
        p = ({64'd0, a} * {64'd0, b}) >> sh;
        if (p[127:64] != 0) return {64{1'b1}};
        return p[63:0];
    endfunction

    // atan(2^-i) in Q32, from an alternating series summed in Q62
    function automatic void build_atan_table();
        longint unsigned p, k;
        longint sum, term;
        atan_q32[0] = longint'(PI_Q60 >> 30);
        for (int i = 1; i < CORDIC_ITERS; i++) begin
            sum = 0;
            p = 64'd1 << (62 - i);
            k = 0;
            while (p != 0) begin
                term = longint'(p / (2 * k + 1));
                sum += k[0] ? -term : term;
                p = (2 * i < 64) ? (p >> (2 * i)) : 0;
                k++;
            end
            atan_q32[i] = sum >>> 30;
        end
    endfunction

    // sine of a Q17 degree angle, Q30 result
    function automatic longint sine_q30(input longint ang);
        longint r, t, z, x, y, dx, dy;
        logic [63:0] mag;
        r = ang % DEG360_Q17;
        if (r < 0) r += DEG360_Q17;
        if (r <= DEG90_Q17) t = r;
        else if (r <= DEG270_Q17) t = DEG180_Q17 - r;
        else t = r - DEG360_Q17;
        mag = mul_shr(t < 0 ? -t : t, RPD, 45);
        z = (t < 0) ? -longint'(mag) : longint'(mag);
        x = longint'(CORDIC_GAIN);
        y = 0;
        for (int i = 0; i < CORDIC_ITERS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_q32[i];
            end else begin
                x += dx; y -= dy; z += atan_q32[i];
            end
        end
        return y;
    endfunction

    function automatic logic [36:0] cell_area_predict(input logic op, input logic [15:0] row);
        longint org, stp, lat, top2, bot2, diff;
        logic [63:0] a, b, area;
        org = grid_origin;
        stp = grid_step;
        lat = org + stp * longint'({48'd0, row});
        if (!op) begin
            top2 = 2 * lat + stp;
            bot2 = 2 * lat - stp;
        end else begin
            top2 = 2 * lat + 2 * stp;
            bot2 = 2 * lat;
        end
        diff = sine_q30(top2) - sine_q30(bot2);
        if (diff < 0) diff = -diff;
        a = 64'(grid_radius) * 64'(grid_radius) * 64'(grid_lon_step);
        b = mul_shr(a, RPD, 52);
        area = mul_shr(b, diff, 46);
        if (area > 64'(AREA_MAX)) area = 64'(AREA_MAX);
        return area[36:0];
    endfunction

    // ------------------------------------------------------------------------
    // Request capture and result check, both at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        logic [36:0] want;
        if (aresetn && s_tvalid && s_tready) begin
            area_expect.push_back(cell_area_predict(s_tuser[0], s_tdata[15:0]));
            rows_sent++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (area_expect.size() == 0) begin
                $display("%0t: unexpected area result, actual %0d", $time, m_tdata[36:0]);
                errors++;
            end else begin
                want = area_expect.pop_front();
                if (m_tdata[36:0] !== want) begin
                    $display("%0t: cell_area mismatch, expected %0d, actual %0d",
                             $time, want, m_tdata[36:0]);
                    errors++;
                end
                if (want == AREA_MAX) saturated_seen++;
                areas_checked++;
            end
        end
    end

    // receiver: long hold when asked, else throttle per mode
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else if (rdy_mode == 0) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // ------------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------------
    // hold the request until accepted; leave s_tvalid high for a back-to-back caller
    task automatic send_row(input logic op, input logic [15:0] row);
        s_tvalid <= 1'b1;
        s_tdata  <= ROW_TDATA_W'(row);
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic idle_gap(input int n);
        s_tvalid <= 1'b0;
        repeat (n) @(negedge aclk);
    endtask

    // drop cfg_valid after each write, before the next write may raise it
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [24:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_LAT_ORIGIN:    grid_origin   = val[23:0];
            REG_LAT_STEP:      grid_step     = val[23:0];
            REG_LON_STEP:      grid_lon_step = val;
            REG_SPHERE_RADIUS: grid_radius   = val[12:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_grid(input int origin, input int step, input int lon, input int radius);
        cfg_write(REG_LAT_ORIGIN, 25'(origin) & 25'hFFFFFF);
        cfg_write(REG_LAT_STEP, 25'(step) & 25'hFFFFFF);
        cfg_write(REG_LON_STEP, 25'(lon));
        cfg_write(REG_SPHERE_RADIUS, 25'(radius));
    endtask

    // wait until every area is back, then let the pipeline settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (area_expect.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [15:0] pick_row();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 255));
            1: return 16'($urandom_range(0, 3)) ? 16'hFFFF : 16'h0;
            default: return 16'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // reset values: zero step gives zero area; an unused index is dropped
    task automatic test_reset_values();
        send_row(1'b0, 16'd0);
        send_row(1'b1, 16'hFFFF);
        drain();
        cfg_write(8'hFF, 25'h1FFFFFF);
        cfg_write(8'h04, 25'h0AAAAAA);
        send_row(1'b0, 16'h5555);
        drain();
    endtask

    task automatic test_directed_edges();
        // one-degree grid from the south pole, Earth radius
        set_grid(-5898240, 65536, 65536, 6371);
        send_row(1'b0, 16'd0);
        send_row(1'b1, 16'd0);
        send_row(1'b1, 16'd89);
        send_row(1'b0, 16'd90);
        send_row(1'b0, 16'd180);     // beyond the north pole, periodic sine
        send_row(1'b1, 16'hFFFF);
        drain();
        // negative steepest step from the north pole
        set_grid(5898240, -4194304, 23592960, 8191);
        send_row(1'b0, 16'd0);       // full-longitude strip straddling the north pole
        send_row(1'b1, 16'd1);
        send_row(1'b1, 16'hFFFF);
        drain();
        set_grid(0, 4194304, 1, 1);  // tiny longitude and radius
        send_row(1'b0, 16'd0);
        send_row(1'b1, 16'h8000);
        send_row(1'b0, 16'h7FFF);
        drain();
        set_grid(-5898240, 0, 23592960, 8191);   // zero step
        send_row(1'b0, 16'd3);
        send_row(1'b1, 16'd3);
        drain();
        set_grid(0, 1, 23592960, 0);   // zero radius
        send_row(1'b1, 16'hFFFF);
        send_row(1'b0, 16'd0);
        drain();
    endtask

    task automatic random_grid();
        int origin, step, lon, radius;
        origin = $urandom_range(0, 11796480) - 5898240;
        step   = $urandom_range(0, 8388608) - 4194304;
        if ($urandom_range(0, 2) == 0) step = $urandom_range(0, 2048) - 1024;
        lon    = $urandom_range(0, 3) == 0 ? 23592960 : $urandom_range(0, 4194304);
        radius = $urandom_range(0, 4) == 0 ? 8191 : $urandom_range(0, 8191);
        set_grid(origin, step, lon, radius);
    endtask

    task automatic test_random_bursts();
        int left;
        for (int phase = 0; phase < 5; phase++) begin
            random_grid();
            rdy_mode = phase % 2;
            left = 90;
            while (left > 0) begin
                for (int n = $urandom_range(1, 20); n > 0 && left > 0; n--) begin
                    send_row(1'($urandom), pick_row());
                    left--;
                end
                if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 6));
            end
            drain();
        end
    endtask

    // hold the receiver for a long stretch and keep offering requests
    task automatic test_output_stall();
        random_grid();
        rdy_mode = 1;
        hold_cycles = 300;
        repeat (100) send_row(1'($urandom), pick_row());
        drain();
        rdy_mode = 0;
    endtask

    initial begin
        errors = 0; rows_sent = 0; areas_checked = 0; saturated_seen = 0;
        rdy_mode = 0; hold_cycles = 0;
        aresetn = 1'b0; s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
        m_tready = 1'b0; cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        grid_origin = '0; grid_step = '0; grid_lon_step = '0; grid_radius = RADIUS_RESET;
        build_atan_table();
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_values();
        test_directed_edges();
        test_random_bursts();
        test_output_stall();

        $display("Checked %0d areas from %0d row requests (%0d saturated).",
                 areas_checked, rows_sent, saturated_seen);
        $display("Grids covered poles, periodic latitudes, zero/negative steps, backpressure.");
        if (errors == 0) begin
            $display("tb_latlon_grid_cell_area_top passed");
        end else begin
            $display("tb_latlon_grid_cell_area_top failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #3000000;
        $display("Timeout with %0d areas outstanding.", area_expect.size());
        $display("tb_latlon_grid_cell_area_top failed");
        $finish;
    end

endmodule
